// File: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SIDT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SIDT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: rtl/sidt_pkg.sv
// Package: types, constants and helper functions for the integer-to-text converter.
`timescale 1ns / 1ps

package sidt_pkg;

    localparam int VALUE_W       = 32;
    localparam int NUM_DIGITS    = 10;
    localparam int DIGIT_W       = 4;
    localparam int POS_W         = 4;
    localparam int CHAR_W        = 6;
    localparam int DABBLE_STEPS  = 8;
    localparam int DABBLE_STAGES = VALUE_W / DABBLE_STEPS;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;

    typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] bcd_t;

    // Work word moving through the shift-and-add-3 stages.
    typedef struct packed {
        logic               neg;
        bcd_t               bcd;
        logic [VALUE_W-1:0] bin;
    } sidt_work_t;

    // Finished number handed to the character serialiser.
    typedef struct packed {
        logic             neg;
        bcd_t             bcd;
        logic [POS_W-1:0] top;
    } sidt_digits_t;

    // One double-dabble step: correct every digit, then shift in the next bit.
    function automatic sidt_work_t dabble_step(input sidt_work_t w);
        sidt_work_t r;
        bcd_t       adj;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            adj[i] = (w.bcd[i] >= 4'd5) ? w.bcd[i] + 4'd3 : w.bcd[i];
        end
        r.neg = w.neg;
        {r.bcd, r.bin} = {adj, w.bin} << 1;
        return r;
    endfunction

    // Index of the most significant non-zero digit; zero for a value of zero.
    function automatic logic [POS_W-1:0] top_digit(input bcd_t bcd);
        logic [POS_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (bcd[i] != '0) begin
                idx = POS_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

// File: rtl/sidt_dabble_stage.sv
// One register stage of the binary-to-BCD pipeline: eight shift-and-add-3 steps.
`timescale 1ns / 1ps

module sidt_dabble_stage
    import sidt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  sidt_work_t in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output sidt_work_t out_data
);

    logic       valid_reg;
    sidt_work_t data_reg;
    sidt_work_t data_next;

    always_comb
    begin
        data_next = in_data;
        for (int s = 0; s < DABBLE_STEPS; s++) begin
            data_next = dabble_step(data_next);
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

// File: rtl/sidt_serializer.sv
// Character serialiser: sends sign and digits, one word per cycle while out_ready.
`timescale 1ns / 1ps

module sidt_serializer
    import sidt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  sidt_digits_t      in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [CHAR_W-1:0] out_char,
    output logic              out_last
);

    logic             busy_reg, busy_next;
    logic             sign_reg, sign_next;
    logic [POS_W-1:0] pos_reg,  pos_next;
    bcd_t             bcd_reg;
    logic             take;
    logic             load;

    assign out_valid = busy_reg;
    assign out_last  = !sign_reg && (pos_reg == '0);
    assign out_char  = sign_reg ? CHAR_MINUS
                                : CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, bcd_reg[pos_reg]};

    assign take     = busy_reg && out_ready;
    assign in_ready = !busy_reg || (take && out_last);
    assign load     = in_valid && in_ready;

    always_comb
    begin
        busy_next = busy_reg;
        sign_next = sign_reg;
        pos_next  = pos_reg;
        if (load)
        begin
            busy_next = 1'b1;
            sign_next = in_data.neg;
            pos_next  = in_data.top;
        end
        else if (take)
        begin
            if (sign_reg)
            begin
                sign_next = 1'b0;
            end
            else if (pos_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                pos_next = pos_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            sign_reg <= 1'b0;
            pos_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            sign_reg <= sign_next;
            pos_reg  <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bcd_reg <= in_data.bcd;
        end
    end

endmodule

// File: rtl/signed_int_to_decimal_ascii.sv
// Top level: signed 32-bit integer to decimal ASCII text, one character per word.
`timescale 1ns / 1ps

// Each input word carries one signed 32-bit integer; the block returns its
// decimal text as a run of output words, one ASCII character each, most
// significant first, with m_tlast on the final character. Negative numbers
// start with '-', leading zeros are dropped and zero prints as a single '0';
// -2147483648 needs no special handling because the magnitude is kept in
// 32 unsigned bits. Internally: one stage forms sign and magnitude, four
// stages each run eight shift-and-add-3 steps (32 in all) to get ten BCD
// digits, one stage finds the leading digit, then a serialiser walks the
// digits out. A number has 1 to 11 characters and they leave at one
// character per cycle while m_tready is high, so the output, not the
// pipeline, sets the sustained rate. The pipeline keeps taking input while a
// number is being sent, up to seven numbers in flight; back-pressure on
// m_tready stalls every stage without loss.

module signed_int_to_decimal_ascii
    import sidt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value (signed)
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [5:0] character, [7:6] zero
    output logic        m_tlast    // last_char
);

    // Stage outputs: index 0 is the sign/magnitude stage, 1..4 the BCD stages.
    logic       stg_valid [DABBLE_STAGES+1];
    logic       stg_ready [DABBLE_STAGES+1];
    sidt_work_t stg_data  [DABBLE_STAGES+1];

    sidt_work_t in_work;
    logic       in_neg;

    logic       mag_valid_reg;
    sidt_work_t mag_data_reg;

    logic         cnt_valid_reg;
    sidt_digits_t cnt_data_reg;
    logic         cnt_ready;

    logic              ser_ready;
    logic [CHAR_W-1:0] ser_char;

    // Sign and magnitude; two's-complement negate wraps the most negative value onto itself.
    assign in_neg      = s_tdata[VALUE_W-1];
    assign in_work.neg = in_neg;
    assign in_work.bcd = '0;
    assign in_work.bin = in_neg ? (~s_tdata + 1'b1) : s_tdata;

    assign s_tready     = !mag_valid_reg || stg_ready[0];
    assign stg_valid[0] = mag_valid_reg;
    assign stg_data[0]  = mag_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mag_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            mag_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            mag_data_reg <= in_work;
        end
    end

    // Binary to BCD, eight bits per stage.
    for (genvar g = 0; g < DABBLE_STAGES; g++) begin : g_dabble
        sidt_dabble_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stg_valid[g]),
            .in_ready  (stg_ready[g]),
            .in_data   (stg_data[g]),
            .out_valid (stg_valid[g+1]),
            .out_ready (stg_ready[g+1]),
            .out_data  (stg_data[g+1])
        );
    end

    // Leading digit search.
    assign cnt_ready                = !cnt_valid_reg || ser_ready;
    assign stg_ready[DABBLE_STAGES] = cnt_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_valid_reg <= 1'b0;
        end
        else if (cnt_ready)
        begin
            cnt_valid_reg <= stg_valid[DABBLE_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stg_valid[DABBLE_STAGES] && cnt_ready)
        begin
            cnt_data_reg.neg <= stg_data[DABBLE_STAGES].neg;
            cnt_data_reg.bcd <= stg_data[DABBLE_STAGES].bcd;
            cnt_data_reg.top <= top_digit(stg_data[DABBLE_STAGES].bcd);
        end
    end

    // Output: sign then digits, one word per cycle while m_tready is high.
    sidt_serializer u_ser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cnt_valid_reg),
        .in_ready  (ser_ready),
        .in_data   (cnt_data_reg),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_char  (ser_char),
        .out_last  (m_tlast)
    );

    assign m_tdata = {{(8-CHAR_W){1'b0}}, ser_char};

endmodule

// File: rtl/sidt_checker.sv
// Port-level checks on the converter output, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sidt_checker
    import sidt_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    logic [CHAR_W-1:0] ch;
    logic              ch_minus;
    logic              ch_digit;
    logic              acc;

    assign ch       = m_tdata[CHAR_W-1:0];
    assign ch_minus = (ch == CHAR_MINUS);
    assign ch_digit = (ch >= CHAR_ZERO) && (ch <= CHAR_ZERO + 6'd9);
    assign acc      = m_tvalid && m_tready;

    // A stalled word holds.
    `SIDT_ASSERT_NXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable({m_tdata, m_tlast}))
    // Only minus or a digit, upper bits clear.
    `SIDT_ASSERT_IMP(a_char, m_tvalid, (m_tdata[7:CHAR_W] == '0) && (ch_minus || ch_digit))
    // A number's characters leave without gaps.
    `SIDT_ASSERT_NXT(a_run, acc && !m_tlast, m_tvalid)
    // Minus is never last and is followed by a non-zero leading digit.
    `SIDT_ASSERT_NXT(a_sign, acc && ch_minus, !ch_minus && (ch != CHAR_ZERO))

endmodule

bind signed_int_to_decimal_ascii sidt_checker u_sidt_checker (.*);

// File: tb/signed_int_to_decimal_ascii_tb.sv
// Self-checking testbench for the signed integer to decimal text converter.
`timescale 1ns / 1ps

// Keeps the characters still due from the block and checks each output word against them.
class decimal_text_scoreboard;

    logic [5:0] char_q[$];
    bit         last_q[$];
    int         errors;
    int         numbers_noted;
    int         chars_checked;

    function new();
        errors        = 0;
        numbers_noted = 0;
        chars_checked = 0;
    endfunction

    // Work out the text for one accepted value and queue its characters.
    function void note_value(input logic [31:0] value);
        logic [31:0] mag;
        logic [3:0]  digits[10];
        int          nd;
        mag = value[31] ? 32'd0 - value : value;
        nd  = 0;
        // Magnitude is unsigned 32 bits, so the most negative value needs no special path
        do
        begin
            digits[nd] = 4'(mag % 32'd10);
            nd++;
            mag = mag / 32'd10;
        end
        while (mag != 32'd0 && nd < 10);
        if (value[31])
        begin
            char_q.push_back(sidt_pkg::CHAR_MINUS);
            last_q.push_back(1'b0);
        end
        for (int i = nd - 1; i >= 0; i--)
        begin
            char_q.push_back(sidt_pkg::CHAR_ZERO + 6'(digits[i]));
            last_q.push_back(i == 0);
        end
        numbers_noted++;
    endfunction

    // Compare one output word with the oldest character still due.
    function void check_char(input logic [7:0] tdata, input logic tlast);
        logic [5:0] exp_char;
        bit         exp_last;
        if (char_q.size() == 0)
        begin
            $display("%0t: unexpected word, expected nothing, actual char %0d last %0b",
                     $time, tdata[5:0], tlast);
            errors++;
            return;
        end
        exp_char = char_q.pop_front();
        exp_last = last_q.pop_front();
        chars_checked++;
        if (tdata[5:0] !== exp_char)
        begin
            $display("%0t: character mismatch, expected %0d, actual %0d",
                     $time, exp_char, tdata[5:0]);
            errors++;
        end
        if (tlast !== exp_last)
        begin
            $display("%0t: last flag mismatch, expected %0b, actual %0b",
                     $time, exp_last, tlast);
            errors++;
        end
        if (tdata[7:6] !== 2'b00)
        begin
            $display("%0t: padding bits mismatch, expected 0, actual %0b",
                     $time, tdata[7:6]);
            errors++;
        end
    endfunction

    function int pending();
        return char_q.size();
    endfunction

endclass

module signed_int_to_decimal_ascii_tb;

    localparam int CLK_HALF    = 6;
    localparam int RESET_CYCLES = 11;
    localparam int RANDOM_COUNT = 200;
    localparam int IDLE_PERCENT = 21;
    // Far above the length of the slowest honest run, which leaves ample margin
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 20;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // [31:0] value (signed)
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // [5:0] character, [7:6] zero
    logic        m_tlast;   // last_char

    decimal_text_scoreboard text_sb;
    bit                     no_gaps;
    int                     cycles;

    // Directed values: zero, one-digit and digit-count boundaries, both signs,
    // the two extremes and alternating bit patterns.
    logic [31:0] corner_values[] = '{
        32'd0, 32'd1, -32'sd1, 32'd9, -32'sd9, 32'd10, -32'sd10, 32'd99, 32'd100,
        32'd12345, -32'sd12345, 32'd999999999, 32'd1000000000, -32'sd1000000000,
        32'h7FFFFFFF, -32'sd2147483647, 32'h80000000, 32'h55555555, 32'hAAAAAAAA,
        32'd2000000000, -32'sd2000000000
    };

    signed_int_to_decimal_ascii dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    // Watchdog: a hung handshake ends the run here
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles, %0d characters still due",
                         cycles, text_sb.pending());
                $display("signed_int_to_decimal_ascii_tb NOT OK");
                $finish;
            end
        end
    end

    // Output side: check each accepted word, then pick next cycle's ready
    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                text_sb.check_char(m_tdata, m_tlast);
            end
            m_tready <= no_gaps || ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    // Offer one value, with random idle cycles first, and hold it until taken.
    // tvalid is left high so back-to-back words need no extra edge.
    task automatic send_value(input logic [31:0] value);
        while (!no_gaps && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 32'($urandom);
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        text_sb.note_value(value);
    endtask

    // Hold the input off until every due character has come out
    task automatic drain_output();
        s_tvalid <= 1'b0;
        while (text_sb.pending() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Mostly values with an even spread of digit counts and signs; some fully random
    function automatic logic [31:0] random_value();
        int     ndig;
        longint lo;
        longint hi;
        longint mag;
        bit     neg;
        if ($urandom_range(0, 3) == 0)
        begin
            return 32'($urandom);
        end
        ndig = $urandom_range(1, 10);
        neg  = $urandom_range(0, 1);
        lo   = 1;
        for (int i = 1; i < ndig; i++)
        begin
            lo = lo * 10;
        end
        hi = (ndig == 10) ? 64'd2147483647 + 64'(neg) : lo * 10 - 1;
        if (ndig == 1)
        begin
            lo = 0;
        end
        mag = lo + (longint'($urandom) % (hi - lo + 1));
        return neg ? 32'(-mag) : 32'(mag);
    endfunction

    initial
    begin
        text_sb  = new();
        no_gaps  = 1'b0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 32'd0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (corner_values[i])
        begin
            send_value(corner_values[i]);
        end
        drain_output();

        for (int i = 0; i < RANDOM_COUNT; i++)
        begin
            // Full-rate stretch on both sides in the middle of the run
            no_gaps = (i >= 60 && i < 120);
            if (i == 150)
            begin
                drain_output();
            end
            send_value(random_value());
        end
        s_tvalid <= 1'b0;
        no_gaps = 1'b0;

        while (text_sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d numbers converted, %0d characters checked: zero, both extremes,",
                 text_sb.numbers_noted, text_sb.chars_checked);
        $display("every digit count with both signs, random gaps and stalls on both sides");
        if (text_sb.errors == 0)
        begin
            $display("signed_int_to_decimal_ascii_tb OK");
        end
        else
        begin
            $display("signed_int_to_decimal_ascii_tb NOT OK");
        end
        $finish;
    end

endmodule
